[sv/ldq_pkg.sv]
// Package for the linear array deque.
// Holds the command and status codes, the beat payload types and the
// controller-to-datapath command and status structs. Depends on nothing.
package ldq_pkg;

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_BACK   = 2'd3;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NO_ROOM = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               now_empty;
        logic               now_full;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic fetch;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_ok;
    } t_dp_stat;

endpackage

[sv/linear_array_deque.sv]
// Top level of the linear array deque: joins the controller and datapath.
// Uses ldq_pkg, ldq_ctrl and ldq_dp.
//
// Usage: each input beat carries a command (push front, push back, pop
// front, pop back) and a value that only pushes use. Every input beat
// yields exactly one output beat with the popped data (0 unless a pop
// succeeded), a status code and the empty and full flags after the step.
// The store is linear: on a non-empty queue, a push at the front fails once the front is at
// slot 0 and a push at the back fails once the back is at the last slot.
// Timing: one item is in flight at a time. A push or a failed pop goes
// from acceptance through the execute state to the result; a successful
// pop also passes the fetch state for the registered read of the element
// store. The next input beat is taken in the cycle after the result is
// taken. While the receiver stalls, the result beat holds and input stays
// stalled.
// Reset (synchronous, active low) empties the queue; store contents are
// not cleared and need not be, as only written slots reach the output.
module linear_array_deque
    import ldq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ldq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    ldq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_data),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_out   (o_out_data)
    );

endmodule

[sv/ldq_ctrl.sv]
// Controller state machine of the linear array deque.
// Sequences load, execute, read fetch and result hand-off. Uses ldq_pkg.
module ldq_ctrl
    import ldq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // A successful pop goes through the fetch state for the store read.
                n_state = i_stat.pop_ok ? ST_FETCH : ST_OUT;
            end
            ST_FETCH: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_cmd.load  = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == ST_EXEC);
    assign o_cmd.fetch = (r_state == ST_FETCH);

    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("load beat not followed by execute");

    a_exec_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (o_cmd.fetch || o_out_valid))
        else $error("execute not followed by fetch or result");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result is pending");

endmodule

[sv/ldq_dp.sv]
// Datapath of the linear array deque: element store, end pointers,
// command decode and result register. Uses ldq_pkg.
module ldq_dp
    import ldq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_beat o_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic signed [31:0] mem [DEPTH];

    logic [PTR_W-1:0]   r_front;
    logic [PTR_W-1:0]   r_back;
    logic               r_empty;
    logic [PTR_W-1:0]   n_front;
    logic [PTR_W-1:0]   n_back;
    logic               n_empty;

    logic [1:0]         r_cmd;
    logic signed [31:0] r_val;
    logic signed [31:0] r_rd_data;
    t_out_beat          r_out;

    logic [1:0]         stat_code;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [PTR_W-1:0]   rd_addr;
    logic               pop_ok;
    logic               full_after;

    always_comb begin
        n_front   = r_front;
        n_back    = r_back;
        n_empty   = r_empty;
        stat_code = STAT_DONE;
        wr_en     = 1'b0;
        wr_addr   = r_front;
        pop_ok    = 1'b0;
        case (r_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (r_empty) begin
                    // The first element always lands in slot 0.
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    n_front = '0;
                    n_back  = '0;
                    n_empty = 1'b0;
                end else if (r_cmd == CMD_PUSH_FRONT) begin
                    if (r_front != '0) begin
                        n_front = r_front - PTR_W'(1);
                        wr_addr = n_front;
                        wr_en   = 1'b1;
                    end else begin
                        stat_code = STAT_NO_ROOM;
                    end
                end else begin
                    if (r_back != LAST) begin
                        n_back  = r_back + PTR_W'(1);
                        wr_addr = n_back;
                        wr_en   = 1'b1;
                    end else begin
                        stat_code = STAT_NO_ROOM;
                    end
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (r_empty) begin
                    stat_code = STAT_EMPTY;
                end else begin
                    pop_ok = 1'b1;
                    if (r_front == r_back) begin
                        n_empty = 1'b1;
                        n_front = '0;
                        n_back  = '0;
                    end else if (r_cmd == CMD_POP_FRONT) begin
                        n_front = r_front + PTR_W'(1);
                    end else begin
                        n_back = r_back - PTR_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign rd_addr    = (r_cmd == CMD_POP_FRONT) ? r_front : r_back;
    assign full_after = !n_empty && (n_front == '0) && (n_back == LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= r_val;
        end
        if (i_cmd.exec) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in.command;
            r_val <= i_in.value;
        end
        if (i_cmd.exec) begin
            r_out.data      <= '0;
            r_out.status    <= stat_code;
            r_out.now_empty <= n_empty;
            r_out.now_full  <= full_after;
        end
        if (i_cmd.fetch) begin
            r_out.data <= r_rd_data;
        end
    end

    assign o_stat.pop_ok = pop_ok;
    assign o_out         = r_out;

    a_empty_at_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_front == '0 && r_back == '0))
        else $error("empty queue with pointers away from slot 0");

    a_ends_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_empty |-> (r_front <= r_back))
        else $error("front pointer passed the back pointer");

    a_back_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_back <= LAST)
        else $error("back pointer beyond the last slot");

endmodule
